// File: hw/rtl/md5t_pkg.sv
package md5t_pkg;

    // Number of MD5 steps, one cell for each.
    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned ROUND_W    = 6;

    // One input word: current identifier and history token, first byte on top.
    typedef struct packed {
        logic [63:0] interface_id;
        logic [63:0] history_token;
    } t_in_word;

    // One output word: new identifier and next history token, first byte on top.
    typedef struct packed {
        logic [63:0] new_interface_id;
        logic [63:0] new_history_token;
    } t_out_word;

    // The four MD5 chaining variables.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_md5_state;

    localparam t_md5_state MD5_IV = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476
    };

    // Padding words of the single block: marker byte and the bit length.
    localparam logic [31:0] PAD_MARKER = 32'h00000080;
    localparam logic [31:0] PAD_LENGTH = 32'd128;

    // Universal/local bit of the first identifier byte.
    localparam int unsigned UL_BIT = 57;

    // Additive constants, one per step.
    localparam logic [31:0] MD5_K [NUM_ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotation amounts, indexed by round group and step within four.
    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Reverse the byte order of a 32-bit word.
    function automatic logic [31:0] bswap32(logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Message word g of the padded block built from one input word.
    function automatic logic [31:0] msg_word(t_in_word w, logic [3:0] g);
        logic [31:0] m;
        case (g)
            4'd0:    m = bswap32(w.interface_id[63:32]);
            4'd1:    m = bswap32(w.interface_id[31:0]);
            4'd2:    m = bswap32(w.history_token[63:32]);
            4'd3:    m = bswap32(w.history_token[31:0]);
            4'd4:    m = PAD_MARKER;
            4'd14:   m = PAD_LENGTH;
            default: m = 32'h0;
        endcase
        return m;
    endfunction

    // One MD5 step.
    function automatic t_md5_state md5_round(t_md5_state st, t_in_word w,
                                             logic [ROUND_W-1:0] idx);
        logic [1:0]  grp;
        logic [3:0]  i4;
        logic [3:0]  g;
        logic [31:0] f;
        logic [31:0] sum;
        logic [4:0]  s;
        logic [63:0] dbl;
        t_md5_state  nx;
        grp = idx[5:4];
        i4  = idx[3:0];
        case (grp)
            2'd0: begin
                f = (st.b & st.c) | (~st.b & st.d);
                g = i4;
            end
            2'd1: begin
                f = (st.d & st.b) | (~st.d & st.c);
                g = 4'(i4 * 4'd5 + 4'd1);
            end
            2'd2: begin
                f = st.b ^ st.c ^ st.d;
                g = 4'(i4 * 4'd3 + 4'd5);
            end
            default: begin
                f = st.c ^ (st.b | ~st.d);
                g = 4'(i4 * 4'd7);
            end
        endcase
        sum  = st.a + f + MD5_K[idx] + msg_word(w, g);
        s    = MD5_S[{grp, idx[1:0]}];
        dbl  = {sum, sum} << s;
        nx.a = st.d;
        nx.b = st.b + dbl[63:32];
        nx.c = st.b;
        nx.d = st.c;
        return nx;
    endfunction

endpackage

// File: hw/rtl/md5t_cell.sv
module md5t_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [md5t_pkg::ROUND_W-1:0] i_round,
    input  logic                         i_valid,
    input  md5t_pkg::t_md5_state         i_state,
    input  md5t_pkg::t_in_word           i_msg,
    output logic                         o_ready,
    input  logic                         i_ready,
    output logic                         o_valid,
    output md5t_pkg::t_md5_state         o_state,
    output md5t_pkg::t_in_word           o_msg
);

    logic                 r_valid;
    md5t_pkg::t_md5_state r_state;
    md5t_pkg::t_in_word   r_msg;
    md5t_pkg::t_md5_state n_state;

    // The step this cell performs on the word passing through it.
    always_comb begin
        n_state = md5t_pkg::md5_round(i_state, i_msg, i_round);
    end

    // The cell takes a word when it is empty or its own word moves on.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Chaining variables and the original word travel together.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
            r_msg   <= i_msg;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_msg   = r_msg;

endmodule

// File: hw/rtl/md5t_out.sv
module md5t_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  md5t_pkg::t_md5_state i_state,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_stall,
    output md5t_pkg::t_out_word  o_word
);

    logic                r_valid;
    md5t_pkg::t_out_word r_word;
    md5t_pkg::t_out_word n_word;
    logic [31:0]         w_a;
    logic [31:0]         w_b;
    logic [31:0]         w_c;
    logic [31:0]         w_d;

    // Final feed-forward addition, conversion to network byte order, and clearing of the universal/local bit.
    always_comb begin
        w_a = i_state.a + md5t_pkg::MD5_IV.a;
        w_b = i_state.b + md5t_pkg::MD5_IV.b;
        w_c = i_state.c + md5t_pkg::MD5_IV.c;
        w_d = i_state.d + md5t_pkg::MD5_IV.d;
        n_word.new_interface_id  = {md5t_pkg::bswap32(w_a), md5t_pkg::bswap32(w_b)};
        n_word.new_interface_id[md5t_pkg::UL_BIT] = 1'b0;
        n_word.new_history_token = {md5t_pkg::bswap32(w_c), md5t_pkg::bswap32(w_d)};
    end

    // Output register: refills whenever it is empty or being taken.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: hw/rtl/temp_interface_id_md5.sv
// Pipeline: a word accepted at a clock edge loads into the first step cell,
// moves on through each of the 64 cells in turn, and then loads the output
// register with the final addition, which drives o_valid, from the last cell.
// Throughput: one word per cycle unless stalled; each cell holds one word and
// a cell that holds a bubble still takes a word while a later stage is stalled.
// Reset: synchronous, active low; clears every valid flag, payload is not reset.
module temp_interface_id_md5 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  md5t_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output md5t_pkg::t_out_word o_word
);

    localparam int unsigned N = md5t_pkg::NUM_ROUNDS;

    logic [N:0]           c_valid;
    logic [N:0]           c_ready;
    md5t_pkg::t_md5_state c_state [N+1];
    md5t_pkg::t_in_word   c_msg   [N+1];

    // Head of the chain: initial chaining variables and the incoming word.
    assign c_valid[0] = i_valid;
    assign c_state[0] = md5t_pkg::MD5_IV;
    assign c_msg[0]   = i_word;
    assign o_stall    = !c_ready[0];

    // One cell for each MD5 step.
    for (genvar k = 0; k < N; k++) begin : g_cell
        md5t_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (md5t_pkg::ROUND_W'(k)),
            .i_valid (c_valid[k]),
            .i_state (c_state[k]),
            .i_msg   (c_msg[k]),
            .o_ready (c_ready[k]),
            .i_ready (c_ready[k+1]),
            .o_valid (c_valid[k+1]),
            .o_state (c_state[k+1]),
            .o_msg   (c_msg[k+1])
        );
    end

    // Digest formation and output register.
    md5t_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[N]),
        .i_state (c_state[N]),
        .o_ready (c_ready[N]),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

`ifndef SYNTHESIS
    // Input is held off only when every cell and the output register are full.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&c_valid[N:1]) && o_valid && i_stall)
        else $error("input stalled while the chain has a free cell");

    // A word leaving the last cell lands in the output register.
    a_last_cell_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_valid[N] && c_ready[N] |=> o_valid)
        else $error("word from the last cell was lost");

    // The universal/local bit of the new identifier is always cleared.
    a_ul_bit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_word.new_interface_id[md5t_pkg::UL_BIT])
        else $error("universal/local bit set in new identifier");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

    // Run shape: random words, the long receiver hold and the watchdog.
    localparam int unsigned RANDOM_WORDS = 1740;
    localparam int unsigned HOLD_AFTER   = 300;
    localparam int unsigned HOLD_CYCLES  = 500;
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned DIR_ROWS     = 12;

    // Universal/local bit of the first identifier byte.
    localparam int unsigned UL_POS = 57;

    // Initial chaining values of the hash.
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Padding of the single block: end marker byte and the length in bits.
    localparam logic [31:0] PAD_END  = 32'h00000080;
    localparam logic [31:0] PAD_BITS = 32'd128;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int unsigned ROT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // One directed row: the input word and, where known by hand, its result.
    typedef struct packed {
        md5t_pkg::t_in_word  stim;
        logic                typed;
        md5t_pkg::t_out_word want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    md5t_pkg::t_in_word  i_word;
    logic                o_valid;
    logic                i_stall;
    md5t_pkg::t_out_word o_word;

    md5t_pkg::t_out_word pending_ids [$];
    md5t_pkg::t_out_word head_id;
    t_dir_row            dir_rows [DIR_ROWS];
    int unsigned         n_mismatch;
    int unsigned         n_accepted;
    int unsigned         quiet_cycles;
    int unsigned         calm_left;
    logic                hold_on;
    logic                hold_done;

    temp_interface_id_md5 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    // Hashes identifier and token as one padded block and derives the new pair.
    function automatic md5t_pkg::t_out_word predict_temp_id(md5t_pkg::t_in_word w);
        logic [127:0]        msg;
        logic [127:0]        digest;
        logic [31:0]         blk [16];
        logic [31:0]         h [4];
        logic [31:0]         va, vb, vc, vd, fn, acc, held;
        int unsigned         step, j, grp, gi, sh;
        md5t_pkg::t_out_word res;
        msg = {w.interface_id, w.history_token};
        for (j = 0; j < 16; j++) begin
            blk[j] = '0;
        end
        // Message bytes go into the block words least significant byte first.
        for (j = 0; j < 16; j++) begin
            blk[j / 4][8 * (j % 4) +: 8] = msg[127 - 8 * j -: 8];
        end
        blk[4]  = PAD_END;
        blk[14] = PAD_BITS;
        va = IV_A;
        vb = IV_B;
        vc = IV_C;
        vd = IV_D;
        for (step = 0; step < 64; step++) begin
            grp = step / 16;
            case (grp)
                0: begin
                    fn = (vb & vc) | (~vb & vd);
                    gi = step;
                end
                1: begin
                    fn = (vd & vb) | (~vd & vc);
                    gi = (5 * step + 1) % 16;
                end
                2: begin
                    fn = vb ^ vc ^ vd;
                    gi = (3 * step + 5) % 16;
                end
                default: begin
                    fn = vc ^ (vb | ~vd);
                    gi = (7 * step) % 16;
                end
            endcase
            acc  = va + fn + ROUND_K[step] + blk[gi];
            sh   = ROT_AMT[grp * 4 + step % 4];
            held = vd;
            vd   = vc;
            vc   = vb;
            vb   = vb + ((acc << sh) | (acc >> (32 - sh)));
            va   = held;
        end
        h[0] = va + IV_A;
        h[1] = vb + IV_B;
        h[2] = vc + IV_C;
        h[3] = vd + IV_D;
        // Digest bytes leave each chaining word least significant byte first.
        for (j = 0; j < 16; j++) begin
            digest[127 - 8 * j -: 8] = h[j / 4][8 * (j % 4) +: 8];
        end
        res = digest;
        res.new_interface_id[UL_POS] = 1'b0;
        return res;
    endfunction

    // Idle cycles before the next word: mostly none or short, a few long,
    // with calm stretches and none at all while the receiver holds off.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (hold_on) begin
            return 0;
        end
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm_left = $urandom_range(20, 120);
        end
        if (roll < 50) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 80);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        n_mismatch++;
    endtask

    // Offers one word and, once it is taken, queues its expected result.
    task automatic offer_word(input md5t_pkg::t_in_word w,
                              input md5t_pkg::t_out_word want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_ids.push_back(want);
        n_accepted++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls with quiet stretches, and one long hold-off
    // that lets the pipeline fill and push back on the sender.
    initial begin
        int unsigned roll;
        int unsigned span;
        i_stall  <= 1'b0;
        hold_on   = 1'b0;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!hold_done && n_accepted >= HOLD_AFTER) begin
                hold_on  = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on   = 1'b0;
                hold_done = 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    span = $urandom_range(100, 300);
                end else begin
                    span = $urandom_range(1, 6);
                end
                i_stall <= 1'b0;
                repeat (span) @(posedge i_clk);
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    if (roll < 40) begin
                        span = $urandom_range(1, 3);
                    end else begin
                        span = $urandom_range(10, 60);
                    end
                    i_stall <= 1'b1;
                    repeat (span) @(posedge i_clk);
                end
            end
        end
    end

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (o_valid && !i_stall) begin
                if (pending_ids.size() == 0) begin
                    report_mismatch("word with nothing expected",
                                    o_word.new_interface_id, '0);
                end else begin
                    head_id = pending_ids.pop_front();
                    if (o_word.new_interface_id !== head_id.new_interface_id) begin
                        report_mismatch("new_interface_id", o_word.new_interface_id,
                                        head_id.new_interface_id);
                    end
                    if (o_word.new_history_token !== head_id.new_history_token) begin
                        report_mismatch("new_history_token", o_word.new_history_token,
                                        head_id.new_history_token);
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Reset, directed words, random words, then drain and verdict.
    initial begin
        md5t_pkg::t_in_word w;
        int unsigned        n;
        int unsigned        kind;
        n_mismatch   = 0;
        n_accepted   = 0;
        quiet_cycles = 0;
        calm_left    = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_word  <= '0;

        // Extremes, alternating bits, single set bits, the universal/local bit
        // set on input, and the published example with its digest.
        dir_rows[0]  = '{'{64'h0, 64'h0}, 1'b0, '0};
        dir_rows[1]  = '{'{64'hffffffffffffffff, 64'hffffffffffffffff}, 1'b0, '0};
        dir_rows[2]  = '{'{64'hffffffffffffffff, 64'h0}, 1'b0, '0};
        dir_rows[3]  = '{'{64'h0, 64'hffffffffffffffff}, 1'b0, '0};
        dir_rows[4]  = '{'{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555}, 1'b0, '0};
        dir_rows[5]  = '{'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa}, 1'b0, '0};
        dir_rows[6]  = '{'{64'h0123456789abcdef, 64'h0123456789abcdef}, 1'b1,
                         '{64'h4462bdea8654776d, 64'h486072ff7074945e}};
        dir_rows[7]  = '{'{64'h8000000000000000, 64'h0000000000000001}, 1'b0, '0};
        dir_rows[8]  = '{'{64'h0000000000000001, 64'h8000000000000000}, 1'b0, '0};
        dir_rows[9]  = '{'{64'h0200000000000000, 64'hfedcba9876543210}, 1'b0, '0};
        dir_rows[10] = '{'{64'h0123456789abcdef, 64'hfedcba9876543210}, 1'b0, '0};
        dir_rows[11] = '{'{64'hffffffff00000000, 64'h00000000ffffffff}, 1'b0, '0};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIR_ROWS; n++) begin
            if (dir_rows[n].typed) begin
                offer_word(dir_rows[n].stim, dir_rows[n].want);
            end else begin
                offer_word(dir_rows[n].stim, predict_temp_id(dir_rows[n].stim));
            end
        end

        // Mostly uniform words; some with one bit set or one bit cleared.
        for (n = 0; n < RANDOM_WORDS; n++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                w = '0;
                w[$urandom_range(0, 127)] = 1'b1;
            end else if (kind == 1) begin
                w = '1;
                w[$urandom_range(0, 127)] = 1'b0;
            end else begin
                w = {$urandom, $urandom, $urandom, $urandom};
            end
            offer_word(w, predict_temp_id(w));
        end
        i_valid <= 1'b0;

        while (pending_ids.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/md5t_pkg.sv
hw/rtl/md5t_cell.sv
hw/rtl/md5t_out.sv
hw/rtl/temp_interface_id_md5.sv
verif/tb.sv
